// File: rtl/gbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gbc_pkg;

    // Default window length and fixed field widths.
    localparam int WINDOW_DEFAULT = 100;
    localparam int SAMPLE_W       = 16;
    localparam int RATE_W         = 17;
    localparam int LIMIT_W        = 16;

    // Port geometry.
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;
    localparam int M_TUSER_W   = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_VARIANCE_LIMIT  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FALLBACK_CENTER = 8'd1;

    // Calibration status codes.
    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_CAL     = 2'd1;
    localparam logic [1:0] ST_FAIL    = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam logic [LIMIT_W-1:0] VARIANCE_LIMIT_RESET = 16'd4;
    localparam sample_t            CENTER_RESET         = 16'sd512;

    typedef struct packed {
        sample_t fb;
        sample_t rl;
    } sample_pair_t;

    // Outcome of the window test carried alongside an item.
    typedef struct packed {
        logic deciding;
        logic fb_pass;
        logic rl_pass;
    } verdict_t;

    // Width of a signed running sum of window samples.
    function automatic int sum_w(input int window);
        return SAMPLE_W + $clog2(window);
    endfunction

    // Width of a running sum of squared samples.
    function automatic int sq_w(input int window);
        return 2 * SAMPLE_W - 1 + $clog2(window);
    endfunction

endpackage

`default_nettype wire

// File: rtl/gbc_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module gbc_accum
    import gbc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sample_pair_t                      in_samples,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sample_pair_t                      out_samples,
    output logic                              out_last,
    output logic signed [sum_w(WINDOW)-1:0]   fb_total,
    output logic signed [sum_w(WINDOW)-1:0]   rl_total,
    output logic        [sq_w(WINDOW)-1:0]    fb_square_total,
    output logic        [sq_w(WINDOW)-1:0]    rl_square_total
);

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = sum_w(WINDOW);
    localparam int SQ_W   = sq_w(WINDOW);
    localparam int PROD_W = 2 * SAMPLE_W;
    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(WINDOW);

    logic [CNT_W-1:0]         count_reg;
    logic                     s1_valid_reg;
    sample_pair_t             s1_samples_reg;
    logic                     s1_last_reg;
    logic                     s2_valid_reg;
    sample_pair_t             s2_samples_reg;
    logic                     s2_last_reg;
    logic [PROD_W-2:0]        s2_fb_sq_reg;
    logic [PROD_W-2:0]        s2_rl_sq_reg;
    logic                     s3_valid_reg;
    sample_pair_t             s3_samples_reg;
    logic                     s3_last_reg;
    logic signed [SUM_W-1:0]  s3_fb_total_reg;
    logic signed [SUM_W-1:0]  s3_rl_total_reg;
    logic [SQ_W-1:0]          s3_fb_sq_total_reg;
    logic [SQ_W-1:0]          s3_rl_sq_total_reg;
    logic signed [SUM_W-1:0]  fb_sum_reg;
    logic signed [SUM_W-1:0]  rl_sum_reg;
    logic [SQ_W-1:0]          fb_sq_sum_reg;
    logic [SQ_W-1:0]          rl_sq_sum_reg;
    logic                     s1_ready;
    logic                     s2_ready;
    logic                     s3_ready;
    logic signed [PROD_W-1:0] fb_prod;
    logic signed [PROD_W-1:0] rl_prod;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // The item that follows a full window is the deciding one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
            if (in_valid)
            begin
                if (count_reg == COUNT_FULL)
                    count_reg <= '0;
                else
                    count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_samples_reg <= in_samples;
            s1_last_reg    <= (count_reg == COUNT_FULL);
        end
    end

    assign fb_prod = s1_samples_reg.fb * s1_samples_reg.fb;
    assign rl_prod = s1_samples_reg.rl * s1_samples_reg.rl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_samples_reg <= s1_samples_reg;
            s2_last_reg    <= s1_last_reg;
            s2_fb_sq_reg   <= fb_prod[PROD_W-2:0];
            s2_rl_sq_reg   <= rl_prod[PROD_W-2:0];
        end
    end

    // Running sums: each item carries a snapshot of them, and the deciding item clears them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            fb_sum_reg    <= '0;
            rl_sum_reg    <= '0;
            fb_sq_sum_reg <= '0;
            rl_sq_sum_reg <= '0;
        end
        else
        begin
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s2_valid_reg && s3_ready)
            begin
                if (s2_last_reg)
                begin
                    fb_sum_reg    <= '0;
                    rl_sum_reg    <= '0;
                    fb_sq_sum_reg <= '0;
                    rl_sq_sum_reg <= '0;
                end
                else
                begin
                    fb_sum_reg    <= fb_sum_reg + SUM_W'(s2_samples_reg.fb);
                    rl_sum_reg    <= rl_sum_reg + SUM_W'(s2_samples_reg.rl);
                    fb_sq_sum_reg <= fb_sq_sum_reg + SQ_W'(s2_fb_sq_reg);
                    rl_sq_sum_reg <= rl_sq_sum_reg + SQ_W'(s2_rl_sq_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_samples_reg     <= s2_samples_reg;
            s3_last_reg        <= s2_last_reg;
            s3_fb_total_reg    <= fb_sum_reg;
            s3_rl_total_reg    <= rl_sum_reg;
            s3_fb_sq_total_reg <= fb_sq_sum_reg;
            s3_rl_sq_total_reg <= rl_sq_sum_reg;
        end
    end

    assign out_valid       = s3_valid_reg;
    assign out_samples     = s3_samples_reg;
    assign out_last        = s3_last_reg;
    assign fb_total        = s3_fb_total_reg;
    assign rl_total        = s3_rl_total_reg;
    assign fb_square_total = s3_fb_sq_total_reg;
    assign rl_square_total = s3_rl_sq_total_reg;

endmodule

`default_nettype wire

// File: rtl/gbc_window_test.sv
`timescale 1ns / 1ps
`default_nettype none

module gbc_window_test
    import gbc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sample_pair_t                      in_samples,
    input  logic                              in_last,
    input  logic signed [sum_w(WINDOW)-1:0]   fb_total,
    input  logic signed [sum_w(WINDOW)-1:0]   rl_total,
    input  logic        [sq_w(WINDOW)-1:0]    fb_square_total,
    input  logic        [sq_w(WINDOW)-1:0]    rl_square_total,
    input  logic        [LIMIT_W-1:0]         variance_limit,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sample_pair_t                      out_samples,
    output verdict_t                          out_verdict,
    output sample_t                           fb_mean,
    output sample_t                           rl_mean
);

    localparam int SUM_W  = sum_w(WINDOW);
    localparam int SQ_W   = sq_w(WINDOW);
    localparam int MAG_W  = SUM_W;
    localparam int MUL_W  = 2 * MAG_W;
    localparam int TEST_W = 2 * SAMPLE_W - 1 + 2 * $clog2(WINDOW);
    localparam int N_SQ   = WINDOW * WINDOW;
    // floor(2^MAG_W / N): the quotient estimate is exact or one short.
    localparam logic [MAG_W-1:0] RECIP   = MAG_W'((1 << MAG_W) / WINDOW);
    localparam logic [MAG_W-1:0] N_MAG   = MAG_W'(WINDOW);
    localparam logic [TEST_W-1:0] N_TEST = TEST_W'(WINDOW);

    // Lane 0 is forward-back, lane 1 right-left.
    logic                     t1_valid_reg;
    sample_pair_t             t1_samples_reg;
    logic                     t1_last_reg;
    logic                     t1_neg_reg  [2];
    logic [MAG_W-1:0]         t1_mag_reg  [2];
    logic [TEST_W-1:0]        t1_nsq_reg  [2];
    logic [TEST_W-1:0]        t1_lim_reg;
    logic                     t2_valid_reg;
    sample_pair_t             t2_samples_reg;
    logic                     t2_last_reg;
    logic                     t2_neg_reg  [2];
    logic [MAG_W-1:0]         t2_mag_reg  [2];
    logic [TEST_W-1:0]        t2_nsq_reg  [2];
    logic [TEST_W-1:0]        t2_mag2_reg [2];
    logic [MAG_W-1:0]         t2_q0_reg   [2];
    logic [TEST_W-1:0]        t2_lim_reg;
    logic                     t3_valid_reg;
    sample_pair_t             t3_samples_reg;
    verdict_t                 t3_verdict_reg;
    sample_t                  t3_mean_reg [2];

    logic                     t1_ready;
    logic                     t2_ready;
    logic                     t3_ready;
    logic signed [SUM_W-1:0]  total   [2];
    logic [SQ_W-1:0]          sq_tot  [2];
    logic                     neg     [2];
    logic [MAG_W-1:0]         mag     [2];
    logic [TEST_W-1:0]        nsq     [2];
    logic [MUL_W-1:0]         mag2    [2];
    logic [MUL_W-1:0]         qprod   [2];
    logic [TEST_W-1:0]        spread  [2];
    logic                     pass    [2];
    logic [MAG_W-1:0]         rem     [2];
    logic [MAG_W-1:0]         quot    [2];
    sample_t                  mean    [2];

    assign t3_ready = !t3_valid_reg || out_ready;
    assign t2_ready = !t2_valid_reg || t3_ready;
    assign t1_ready = !t1_valid_reg || t2_ready;
    assign in_ready = t1_ready;

    assign total[0]  = fb_total;
    assign total[1]  = rl_total;
    assign sq_tot[0] = fb_square_total;
    assign sq_tot[1] = rl_square_total;

    // Magnitudes and N * sum of squares.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            neg[i] = total[i][SUM_W-1];
            mag[i] = neg[i] ? MAG_W'(-total[i]) : MAG_W'(total[i]);
            nsq[i] = TEST_W'(sq_tot[i]) * N_TEST;
        end
    end

    // Squared sum and reciprocal product for the mean.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            mag2[i]  = MUL_W'(t1_mag_reg[i]) * MUL_W'(t1_mag_reg[i]);
            qprod[i] = MUL_W'(t1_mag_reg[i]) * MUL_W'(RECIP);
        end
    end

    // Variance comparison and quotient correction.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            spread[i] = t2_nsq_reg[i] - t2_mag2_reg[i];
            pass[i]   = spread[i] < t2_lim_reg;
            rem[i]    = t2_mag_reg[i] - t2_q0_reg[i] * N_MAG;
            quot[i]   = (rem[i] >= N_MAG) ? t2_q0_reg[i] + MAG_W'(1) : t2_q0_reg[i];
            mean[i]   = t2_neg_reg[i] ? -quot[i][SAMPLE_W-1:0] : quot[i][SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
        end
        else
        begin
            if (t1_ready)
                t1_valid_reg <= in_valid;
            if (t2_ready)
                t2_valid_reg <= t1_valid_reg;
            if (t3_ready)
                t3_valid_reg <= t2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (t1_ready)
        begin
            t1_samples_reg <= in_samples;
            t1_last_reg    <= in_last;
            t1_lim_reg     <= TEST_W'(variance_limit) * TEST_W'(N_SQ);
            for (int i = 0; i < 2; i++)
            begin
                t1_neg_reg[i] <= neg[i];
                t1_mag_reg[i] <= mag[i];
                t1_nsq_reg[i] <= nsq[i];
            end
        end
        if (t2_ready)
        begin
            t2_samples_reg <= t1_samples_reg;
            t2_last_reg    <= t1_last_reg;
            t2_lim_reg     <= t1_lim_reg;
            for (int i = 0; i < 2; i++)
            begin
                t2_neg_reg[i]  <= t1_neg_reg[i];
                t2_mag_reg[i]  <= t1_mag_reg[i];
                t2_nsq_reg[i]  <= t1_nsq_reg[i];
                t2_mag2_reg[i] <= mag2[i][TEST_W-1:0];
                t2_q0_reg[i]   <= qprod[i][MUL_W-1:MAG_W];
            end
        end
        if (t3_ready)
        begin
            t3_samples_reg          <= t2_samples_reg;
            t3_verdict_reg.deciding <= t2_last_reg;
            t3_verdict_reg.fb_pass  <= pass[0];
            t3_verdict_reg.rl_pass  <= pass[1];
            t3_mean_reg[0]          <= mean[0];
            t3_mean_reg[1]          <= mean[1];
        end
    end

    assign out_valid   = t3_valid_reg;
    assign out_samples = t3_samples_reg;
    assign out_verdict = t3_verdict_reg;
    assign fb_mean     = t3_mean_reg[0];
    assign rl_mean     = t3_mean_reg[1];

endmodule

`default_nettype wire

// File: rtl/gbc_output.sv
`timescale 1ns / 1ps
`default_nettype none

module gbc_output
    import gbc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  sample_pair_t              in_samples,
    input  verdict_t                  in_verdict,
    input  sample_t                   fb_mean,
    input  sample_t                   rl_mean,
    input  sample_t                   fallback_center,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                cal_status,
    output logic                      rate_valid,
    output logic signed [RATE_W-1:0]  fb_rate,
    output logic signed [RATE_W-1:0]  rl_rate
);

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    sample_t                  fb_center_reg;
    sample_t                  fb_center_next;
    sample_t                  rl_center_reg;
    sample_t                  rl_center_next;
    logic                     out_valid_reg;
    logic [1:0]               status_reg;
    logic                     rate_valid_reg;
    logic signed [RATE_W-1:0] fb_rate_reg;
    logic signed [RATE_W-1:0] rl_rate_reg;
    logic                     calibrated;
    logic signed [RATE_W-1:0] fb_rate_next;
    logic signed [RATE_W-1:0] rl_rate_next;

    assign in_ready = !out_valid_reg || out_ready;

    // Calibration is permanent, so deciding items seen afterwards are ignored.
    always_comb
    begin
        state_next     = state_reg;
        fb_center_next = fb_center_reg;
        rl_center_next = rl_center_reg;
        if (in_valid && in_ready && in_verdict.deciding && state_reg != ST_CAL)
        begin
            if (in_verdict.fb_pass && in_verdict.rl_pass)
            begin
                state_next     = ST_CAL;
                fb_center_next = fb_mean;
                rl_center_next = rl_mean;
            end
            else
            begin
                state_next     = ST_FAIL;
                fb_center_next = fallback_center;
                rl_center_next = fallback_center;
            end
        end
    end

    assign calibrated   = (state_next == ST_CAL);
    assign fb_rate_next = calibrated ?
                          RATE_W'(in_samples.fb) - RATE_W'(fb_center_next) : '0;
    assign rl_rate_next = calibrated ?
                          RATE_W'(in_samples.rl) - RATE_W'(rl_center_next) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            fb_center_reg <= CENTER_RESET;
            rl_center_reg <= CENTER_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fb_center_reg <= fb_center_next;
            rl_center_reg <= rl_center_next;
            if (in_ready)
                out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            status_reg     <= state_next;
            rate_valid_reg <= calibrated;
            fb_rate_reg    <= fb_rate_next;
            rl_rate_reg    <= rl_rate_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cal_status = status_reg;
    assign rate_valid = rate_valid_reg;
    assign fb_rate    = fb_rate_reg;
    assign rl_rate    = rl_rate_reg;

endmodule

`default_nettype wire

// File: rtl/gyro_bias_calibrator.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle while the master side accepts results, sustained by a
// seven-register pipeline (input, squaring, accumulation, variance products, quotient
// estimate, test and correction, output).
// Reset (rst_n, asynchronous, active low) empties the pipeline, clears the sums and the
// window count, returns the status to collecting, both centres to 512 and the two
// configuration registers to a variance limit of 4 and a fallback centre of 512.

module gyro_bias_calibrator
    import gbc_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input samples
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,   // fb_sample[15:0], rl_sample[31:16]
    // Results
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [M_TDATA_W-1:0]   m_axis_tdata,   // fb_rate[16:0], rl_rate[33:17], zero pad
    output logic [M_TUSER_W-1:0]   m_axis_tuser,   // cal_status[1:0], rate_valid[2]
    // Configuration writes
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int SUM_W = sum_w(WINDOW);
    localparam int SQ_W  = sq_w(WINDOW);

    // Configuration registers. The user must see that they are only written while the block
    // is idle, so the pipeline may read them directly; the block itself does not enforce this.
    logic [LIMIT_W-1:0]       variance_limit_reg;
    sample_t                  fallback_center_reg;

    sample_pair_t             in_samples;

    // Accumulator to window test.
    logic                     acc_valid;
    logic                     acc_ready;
    sample_pair_t             acc_samples;
    logic                     acc_last;
    logic signed [SUM_W-1:0]  fb_total;
    logic signed [SUM_W-1:0]  rl_total;
    logic [SQ_W-1:0]          fb_square_total;
    logic [SQ_W-1:0]          rl_square_total;

    // Window test to output stage.
    logic                     test_valid;
    logic                     test_ready;
    sample_pair_t             test_samples;
    verdict_t                 test_verdict;
    sample_t                  fb_mean;
    sample_t                  rl_mean;

    logic [1:0]               cal_status;
    logic                     rate_valid;
    logic signed [RATE_W-1:0] fb_rate;
    logic signed [RATE_W-1:0] rl_rate;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variance_limit_reg  <= VARIANCE_LIMIT_RESET;
            fallback_center_reg <= CENTER_RESET;
        end
        else if (cfg_we)
        begin
            // Writes to indexes outside the register list fall through and are dropped.
            unique case (cfg_index)
                REG_VARIANCE_LIMIT:  variance_limit_reg  <= cfg_wdata;
                REG_FALLBACK_CENTER: fallback_center_reg <= sample_t'(cfg_wdata);
                default: ;
            endcase
        end
    end

    assign in_samples.fb = sample_t'(s_axis_tdata[SAMPLE_W-1:0]);
    assign in_samples.rl = sample_t'(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]);

    // Window counting, squaring and the running sums. Sums keep running after
    // calibration, but nothing downstream uses them once the status is final.
    gbc_accum #(
        .WINDOW (WINDOW)
    ) u_accum (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_samples      (in_samples),
        .out_valid       (acc_valid),
        .out_ready       (acc_ready),
        .out_samples     (acc_samples),
        .out_last        (acc_last),
        .fb_total        (fb_total),
        .rl_total        (rl_total),
        .fb_square_total (fb_square_total),
        .rl_square_total (rl_square_total)
    );

    // Exact integer variance test and mean (truncated towards zero) per axis.
    gbc_window_test #(
        .WINDOW (WINDOW)
    ) u_window_test (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (acc_valid),
        .in_ready        (acc_ready),
        .in_samples      (acc_samples),
        .in_last         (acc_last),
        .fb_total        (fb_total),
        .rl_total        (rl_total),
        .fb_square_total (fb_square_total),
        .rl_square_total (rl_square_total),
        .variance_limit  (variance_limit_reg),
        .out_valid       (test_valid),
        .out_ready       (test_ready),
        .out_samples     (test_samples),
        .out_verdict     (test_verdict),
        .fb_mean         (fb_mean),
        .rl_mean         (rl_mean)
    );

    // Status and centres are applied here, in item order, so each item sees the
    // calibration left by the latest deciding item up to and including itself.
    gbc_output u_output (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (test_valid),
        .in_ready        (test_ready),
        .in_samples      (test_samples),
        .in_verdict      (test_verdict),
        .fb_mean         (fb_mean),
        .rl_mean         (rl_mean),
        .fallback_center (fallback_center_reg),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .cal_status      (cal_status),
        .rate_valid      (rate_valid),
        .fb_rate         (fb_rate),
        .rl_rate         (rl_rate)
    );

    assign m_axis_tdata = {{(M_TDATA_W - 2 * RATE_W){1'b0}}, rl_rate, fb_rate};
    assign m_axis_tuser = {rate_valid, cal_status};

endmodule

`default_nettype wire

// File: rtl/gbc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module gbc_checker
    import gbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic [M_TUSER_W-1:0] m_axis_tuser
);

    logic cal_seen_reg;

    // Remembers that a calibrated result has been transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cal_seen_reg <= 1'b0;
        else if (m_axis_tvalid && m_axis_tready && m_axis_tuser[1:0] == ST_CAL)
            cal_seen_reg <= 1'b1;
    end

    a_rate_valid_follows_status: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[2] == (m_axis_tuser[1:0] == ST_CAL))
    ) else $error("rate_valid disagrees with cal_status");

    a_rates_zero_when_invalid: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[2]) |-> (m_axis_tdata == '0)
    ) else $error("rates not zero while rate_valid is low");

    a_calibration_sticky: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && cal_seen_reg) |-> (m_axis_tuser[1:0] == ST_CAL)
    ) else $error("status left calibrated without reset");

    a_result_held_when_stalled: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    ) else $error("stalled result changed");

endmodule

bind gyro_bias_calibrator gbc_checker u_gbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
